// ----- hdl/assm_pkg.sv -----
// Shared types and constants for the actuator step and stall monitor.
// Used by actuator_step_stall_monitor_unit; no dependencies.

package assm_pkg;

    localparam int CMD_W      = 3;
    localparam int VALUE_W    = 32;
    localparam int DRIVE_W    = 9;
    localparam int DIR_W      = 2;
    localparam int CNT_W      = 32;
    localparam int WIN_W      = 16;
    localparam int ADDR_W     = 4;
    localparam int APB_DATA_W = 32;
    localparam int OUT_DATA_W = 144;

    // Command carried in tuser of the input stream
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK         = 3'd0,
        CMD_STEP_IN      = 3'd1,
        CMD_STEP_OUT     = 3'd2,
        CMD_SET_SPEED    = 3'd3,
        CMD_CHECK        = 3'd4,
        CMD_SET_POSITION = 3'd5,
        CMD_CLEAR_STEPS  = 3'd6,
        CMD_RESTART_IDLE = 3'd7
    } t_cmd;

    // Motion direction: halted, extending (outward) or retracting (inward)
    typedef enum logic [DIR_W-1:0] {
        MOVE_NONE = 2'd0,
        MOVE_OUT  = 2'd1,
        MOVE_IN   = 2'd2
    } t_dir;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_INVERT_DRIVE    = 2'd0;
    localparam logic [1:0] REG_STALL_MIN_STEPS = 2'd1;
    localparam logic [1:0] REG_STALL_WINDOW_MS = 2'd2;
    localparam logic [1:0] REG_IDLE_WINDOW_MS  = 2'd3;

    localparam logic signed [VALUE_W-1:0] SPEED_MAX = 32'sd255;
    localparam logic signed [VALUE_W-1:0] SPEED_MIN = -32'sd255;

    localparam logic [WIN_W-1:0] STALL_MIN_RST = 16'd10;
    localparam logic [WIN_W-1:0] STALL_WIN_RST = 16'd1000;
    localparam logic [WIN_W-1:0] IDLE_WIN_RST  = 16'd1000;

endpackage

// ----- hdl/actuator_step_stall_monitor_unit.sv -----
// Actuator step counter, position tracker and stall/idle monitor.
// Depends on assm_pkg for commands, directions and register indexes.
//
// One command enters per cycle and gives its result in the next cycle; the
// whole state update is a single pass of 32-bit adders and comparators into
// the state and result registers, so the block sustains one item per clock
// as long as the result side keeps taking transfers. The result register
// holds one result under back-pressure while the input stays open whenever
// that result is taken in the same cycle.

module actuator_step_stall_monitor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [assm_pkg::VALUE_W-1:0]        s_axis_tdata,  // [31:0] value
    input  logic [assm_pkg::CMD_W-1:0]          s_axis_tuser,  // [2:0] cmd
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [8:0] drive, [10:9] direction, [11] check_done, [12] stall_res,
    // [44:13] inward_steps, [76:45] outward_steps, [108:77] position_now,
    // [109] idle, [141:110] idle_time_ms, [143:142] zero
    output logic [assm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [assm_pkg::ADDR_W-1:0]         paddr,
    input  logic [assm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [assm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import assm_pkg::*;

    // configuration registers
    logic             r_invert_drive;
    logic [WIN_W-1:0] r_stall_min_steps;
    logic [WIN_W-1:0] r_stall_window_ms;
    logic [WIN_W-1:0] r_idle_window_ms;

    // monitor state
    logic signed [DRIVE_W-1:0] r_drive, n_drive;
    t_dir                      r_dir, n_dir;
    logic [CNT_W-1:0]          r_in_cnt, n_in_cnt;
    logic [CNT_W-1:0]          r_out_cnt, n_out_cnt;
    logic [CNT_W-1:0]          r_in_at_chk, n_in_at_chk;
    logic [CNT_W-1:0]          r_out_at_chk, n_out_at_chk;
    logic [CNT_W-1:0]          r_pos, n_pos;
    logic [CNT_W-1:0]          r_ms, n_ms;
    logic [CNT_W-1:0]          r_chk_stamp, n_chk_stamp;
    logic                      r_chk_armed, n_chk_armed;
    logic [CNT_W-1:0]          r_move_stamp, n_move_stamp;
    logic                      r_has_moved, n_has_moved;

    // result register
    logic             r_m_valid;
    logic             r_done, n_done;
    logic             r_stall, n_stall;
    logic             r_idle, n_idle;
    logic [CNT_W-1:0] r_idle_time, n_idle_time;

    logic                      w_accept;
    logic                      w_cfg_wr;
    t_cmd                      w_cmd;
    logic signed [VALUE_W-1:0] w_value;
    logic signed [DRIVE_W-1:0] w_speed;
    logic [CNT_W-1:0]          w_stamp_eff;
    logic [CNT_W-1:0]          w_elapsed;
    logic                      w_eval;
    logic [CNT_W-1:0]          w_delta;
    logic                      w_low_steps;

    assign pready        = 1'b1;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign w_cmd         = t_cmd'(s_axis_tuser);
    assign w_value       = $signed(s_axis_tdata);

    always_comb begin
        case (paddr[3:2])
            REG_INVERT_DRIVE:    prdata = {{(APB_DATA_W-1){1'b0}}, r_invert_drive};
            REG_STALL_MIN_STEPS: prdata = {{(APB_DATA_W-WIN_W){1'b0}}, r_stall_min_steps};
            REG_STALL_WINDOW_MS: prdata = {{(APB_DATA_W-WIN_W){1'b0}}, r_stall_window_ms};
            REG_IDLE_WINDOW_MS:  prdata = {{(APB_DATA_W-WIN_W){1'b0}}, r_idle_window_ms};
            default:             prdata = '0;
        endcase
    end

    // clamp the speed request to the drive range
    always_comb begin
        if (w_value > SPEED_MAX) begin
            w_speed = SPEED_MAX[DRIVE_W-1:0];
        end else if (w_value < SPEED_MIN) begin
            w_speed = SPEED_MIN[DRIVE_W-1:0];
        end else begin
            w_speed = w_value[DRIVE_W-1:0];
        end
    end

    // stall window: an unarmed check starts its window now
    assign w_stamp_eff = r_chk_armed ? r_chk_stamp : r_ms;
    assign w_elapsed   = r_ms - w_stamp_eff;
    assign w_eval      = (r_dir != MOVE_NONE) &&
                         (w_elapsed >= {{(CNT_W-WIN_W){1'b0}}, r_stall_window_ms});

    // a count that fell below its baseline gives a zero delta
    always_comb begin
        if (r_dir == MOVE_OUT) begin
            w_delta = (r_out_cnt >= r_out_at_chk) ? (r_out_cnt - r_out_at_chk) : '0;
        end else begin
            w_delta = (r_in_cnt >= r_in_at_chk) ? (r_in_cnt - r_in_at_chk) : '0;
        end
    end

    assign w_low_steps = (w_delta < {{(CNT_W-WIN_W){1'b0}}, r_stall_min_steps});

    always_comb begin
        n_drive      = r_drive;
        n_dir        = r_dir;
        n_in_cnt     = r_in_cnt;
        n_out_cnt    = r_out_cnt;
        n_in_at_chk  = r_in_at_chk;
        n_out_at_chk = r_out_at_chk;
        n_pos        = r_pos;
        n_ms         = r_ms;
        n_chk_stamp  = r_chk_stamp;
        n_chk_armed  = r_chk_armed;
        n_move_stamp = r_move_stamp;
        n_has_moved  = r_has_moved;
        n_done       = 1'b0;
        n_stall      = 1'b0;
        case (w_cmd)
            CMD_TICK: begin
                n_ms = r_ms + 1'b1;
            end
            CMD_STEP_IN: begin
                n_in_cnt     = r_in_cnt + 1'b1;
                n_pos        = r_pos - 1'b1;
                n_move_stamp = r_ms;
                n_has_moved  = 1'b1;
            end
            CMD_STEP_OUT: begin
                n_out_cnt    = r_out_cnt + 1'b1;
                n_pos        = r_pos + 1'b1;
                n_move_stamp = r_ms;
                n_has_moved  = 1'b1;
            end
            CMD_SET_SPEED: begin
                if (w_speed == '0) begin
                    n_drive = '0;
                    n_dir   = MOVE_NONE;
                end else begin
                    n_drive = r_invert_drive ? -w_speed : w_speed;
                    n_dir   = w_speed[DRIVE_W-1] ? MOVE_IN : MOVE_OUT;
                end
            end
            CMD_CHECK: begin
                if (r_dir != MOVE_NONE) begin
                    n_chk_armed = 1'b1;
                    n_chk_stamp = w_stamp_eff;
                    if (w_eval) begin
                        n_done       = 1'b1;
                        n_stall      = w_low_steps;
                        n_in_at_chk  = r_in_cnt;
                        n_out_at_chk = r_out_cnt;
                        n_chk_stamp  = r_ms;
                    end
                end
            end
            CMD_SET_POSITION: begin
                n_pos = s_axis_tdata;
            end
            CMD_CLEAR_STEPS: begin
                n_in_cnt  = '0;
                n_out_cnt = '0;
            end
            CMD_RESTART_IDLE: begin
                n_move_stamp = r_ms;
            end
            default: begin
                n_move_stamp = r_ms;
            end
        endcase
        n_idle_time = n_has_moved ? (n_ms - n_move_stamp) : '0;
        n_idle      = n_has_moved &&
                      (n_idle_time >= {{(CNT_W-WIN_W){1'b0}}, r_idle_window_ms});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_drive    <= 1'b0;
            r_stall_min_steps <= STALL_MIN_RST;
            r_stall_window_ms <= STALL_WIN_RST;
            r_idle_window_ms  <= IDLE_WIN_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_INVERT_DRIVE:    r_invert_drive    <= pwdata[0];
                REG_STALL_MIN_STEPS: r_stall_min_steps <= pwdata[WIN_W-1:0];
                REG_STALL_WINDOW_MS: r_stall_window_ms <= pwdata[WIN_W-1:0];
                REG_IDLE_WINDOW_MS:  r_idle_window_ms  <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive      <= '0;
            r_dir        <= MOVE_NONE;
            r_in_cnt     <= '0;
            r_out_cnt    <= '0;
            r_in_at_chk  <= '0;
            r_out_at_chk <= '0;
            r_pos        <= '0;
            r_ms         <= '0;
            r_chk_stamp  <= '0;
            r_chk_armed  <= 1'b0;
            r_move_stamp <= '0;
            r_has_moved  <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_drive      <= n_drive;
                r_dir        <= n_dir;
                r_in_cnt     <= n_in_cnt;
                r_out_cnt    <= n_out_cnt;
                r_in_at_chk  <= n_in_at_chk;
                r_out_at_chk <= n_out_at_chk;
                r_pos        <= n_pos;
                r_ms         <= n_ms;
                r_chk_stamp  <= n_chk_stamp;
                r_chk_armed  <= n_chk_armed;
                r_move_stamp <= n_move_stamp;
                r_has_moved  <= n_has_moved;
                r_m_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with the state it reports
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_done      <= n_done;
            r_stall     <= n_stall;
            r_idle      <= n_idle;
            r_idle_time <= n_idle_time;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_idle_time, r_idle, r_pos, r_out_cnt, r_in_cnt,
                            r_stall, r_done, r_dir, r_drive};

    // a result only reports a window for a check command
    a_done_only_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd != CMD_CHECK)) |=> !r_done)
        else $error("window result on a non-check command");

    a_stall_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (!r_stall || r_done))
        else $error("stall flagged without a finished window");

    a_drive_matches_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_drive == '0) == (r_dir == MOVE_NONE)))
        else $error("drive value and direction disagree");

    a_never_moved_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !n_has_moved) |=> (!r_idle && (r_idle_time == '0)))
        else $error("idle reported before the first step");

    a_step_out_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_STEP_OUT)) |=> (r_pos == $past(r_pos) + 1'b1))
        else $error("outward step did not advance position");

endmodule
